/* src/assert_macros.svh */
// Assertion macros shared by the analog delta event scan RTL.
// Included by files that carry concurrent checks; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/ades_pkg.sv */
// Shared constants, types and command/status structs of the analog delta event scan.
// Used by ades_ctrl, ades_dp and analog_delta_event_scan_top; depends on nothing.
package ades_pkg;

	localparam int CHANNELS = 8;
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W    = $clog2(CHANNELS + 1);
	localparam int CFG_W    = 4;
	localparam int SAMPLE_W = 16;
	localparam int SEL_W    = 3;
	localparam int OP_W     = 2;

	typedef enum logic [OP_W-1:0] {
		OP_STORE = 2'd0,
		OP_DELTA = 2'd1,
		OP_CHECK = 2'd2
	} ades_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} ades_state_t;

	typedef struct packed {
		logic wr_sample;
		logic wr_delta;
		logic start;
		logic step;
		logic load;
		logic update;
	} ades_cmd_t;

	typedef struct packed {
		logic hit;
		logic scan_end;
		logic out_free;
	} ades_sts_t;

endpackage

/* src/ades_ctrl.sv */
// Controller of the analog delta event scan: input handshake and the scan sequencer.
// Depends on ades_pkg; drives the datapath ades_dp through ades_cmd_t / ades_sts_t.
module ades_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [ades_pkg::OP_W-1:0] op,
	output logic                      in_ready,
	input  ades_pkg::ades_sts_t       sts,
	output ades_pkg::ades_cmd_t       cmd
);
	import ades_pkg::*;

	ades_state_t state_q;
	ades_state_t state_nxt;
	logic        accept;
	logic        finish;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	// The scan is over once a channel fires or the channel count is exhausted.
	assign finish   = sts.hit || sts.scan_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && op == OP_CHECK) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (finish && sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.wr_sample = accept && op == OP_STORE;
				cmd.wr_delta  = accept && op == OP_DELTA;
				cmd.start     = accept && op == OP_CHECK;
			end
			ST_SCAN: begin
				// A finished result waits here until the output register can take it.
				cmd.step   = !finish;
				cmd.load   = finish && sts.out_free;
				cmd.update = sts.hit && sts.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

/* src/ades_dp.sv */
// Datapath of the analog delta event scan: channel stores, scan index, compare and result register.
// Depends on ades_pkg; commanded by ades_ctrl.
module ades_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ades_pkg::ades_cmd_t           cmd,
	output ades_pkg::ades_sts_t           sts,
	input  logic [ades_pkg::SEL_W-1:0]    chan_sel,
	input  logic [ades_pkg::SAMPLE_W-1:0] value,
	input  logic                          cfg_wr_en,
	input  logic [ades_pkg::CFG_W-1:0]    cfg_wr_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          out_found,
	output logic [ades_pkg::SEL_W-1:0]    out_channel
);
	import ades_pkg::*;

	logic [SAMPLE_W-1:0] sample_q   [CHANNELS];
	logic [SAMPLE_W-1:0] reported_q [CHANNELS];
	logic [SAMPLE_W-1:0] delta_q    [CHANNELS];
	logic [CFG_W-1:0]    chan_count_q;
	logic [CNT_W-1:0]    limit_q;
	logic [CNT_W-1:0]    idx_q;
	logic                out_valid_q;
	logic                out_found_q;
	logic [SEL_W-1:0]    out_channel_q;

	logic [CH_W-1:0]     rd_idx;
	logic [CH_W-1:0]     wr_idx;
	logic                sel_ok;
	logic [SAMPLE_W-1:0] cur_sample;
	logic [SAMPLE_W-1:0] cur_reported;
	logic [SAMPLE_W-1:0] cur_delta;
	logic [SAMPLE_W:0]   diff;
	logic [SAMPLE_W:0]   abs_diff;
	logic                delta_pos;
	logic [CNT_W-1:0]    limit_nxt;

	assign rd_idx       = idx_q[CH_W-1:0];
	assign wr_idx       = CH_W'(chan_sel);
	assign sel_ok       = (int'(chan_sel) < CHANNELS);
	assign cur_sample   = sample_q[rd_idx];
	assign cur_reported = reported_q[rd_idx];
	assign cur_delta    = delta_q[rd_idx];

	// Exact 17-bit difference, so a full-scale swing does not wrap.
	assign diff      = {cur_sample[SAMPLE_W-1], cur_sample}
	                 - {cur_reported[SAMPLE_W-1], cur_reported};
	assign abs_diff  = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
	assign delta_pos = !cur_delta[SAMPLE_W-1] && (cur_delta != '0);

	assign limit_nxt = (int'(chan_count_q) > CHANNELS) ? CNT_W'(CHANNELS)
	                                                   : CNT_W'(chan_count_q);

	assign sts.scan_end = (idx_q >= limit_q);
	assign sts.hit      = !sts.scan_end && delta_pos && (abs_diff >= {1'b0, cur_delta});
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				sample_q[i]   <= '0;
				reported_q[i] <= '0;
				delta_q[i]    <= '0;
			end
		end else begin
			if (cmd.wr_sample && sel_ok) begin
				sample_q[wr_idx] <= value;
			end
			if (cmd.wr_delta && sel_ok) begin
				delta_q[wr_idx] <= value;
			end
			if (cmd.update) begin
				reported_q[rd_idx] <= cur_sample;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_count_q <= '0;
			limit_q      <= '0;
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				chan_count_q <= cfg_wr_data;
			end
			if (cmd.start) begin
				limit_q <= limit_nxt;
				idx_q   <= '0;
			end else if (cmd.step) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_found_q   <= sts.hit;
			out_channel_q <= sts.hit ? SEL_W'(rd_idx) : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_found   = out_found_q;
	assign out_channel = out_channel_q;

endmodule

/* src/analog_delta_event_scan_top.sv */
// Channel     | Direction | Transfer content
// s_axis      | in        | tuser: op; tdata: chan_sel, value
// m_axis      | out       | tuser: event_found; tdata: event_channel
// cfg_wr      | in        | channels_in_use, written whenever cfg_wr_en is high
//
// A store or delta write is taken on acceptance. After a check is accepted, the scan sequencer
// visits the channels one at a time, up to channels_in_use (capped at 8), until one fires.
// The output register frees the input side: writes are taken while a result waits.
// A finished check holds in the scan state while the output register is still full.
// Reset is asynchronous and clears all stores, the channel count and the result valid.
//
// Top level of the analog delta event scan; instantiates ades_ctrl and ades_dp.
// Depends on ades_pkg and assert_macros.svh.
`include "assert_macros.svh"

module analog_delta_event_scan_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [23:0]                s_axis_tdata,  // chan_sel[2:0], value[18:3], zero pad
	input  logic [ades_pkg::OP_W-1:0]  s_axis_tuser,  // op[1:0]
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [7:0]                 m_axis_tdata,  // event_channel[2:0], zero pad
	output logic                       m_axis_tuser,  // event_found[0]
	input  logic                       cfg_wr_en,
	input  logic [ades_pkg::CFG_W-1:0] cfg_wr_data
);
	import ades_pkg::*;

	ades_cmd_t        cmd;
	ades_sts_t        sts;
	logic [SEL_W-1:0] chan_sel;
	logic [SAMPLE_W-1:0] value;
	logic [SEL_W-1:0] event_channel;
	logic             event_found;

	assign chan_sel = s_axis_tdata[SEL_W-1:0];
	assign value    = s_axis_tdata[SEL_W+SAMPLE_W-1:SEL_W];

	ades_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.op       (s_axis_tuser),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ades_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.chan_sel    (chan_sel),
		.value       (value),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_found   (event_found),
		.out_channel (event_channel)
	);

	assign m_axis_tdata = {(8 - SEL_W)'(0), event_channel};
	assign m_axis_tuser = event_found;

	`ASSERT_IMPL(a_load_only_when_free, clk, arst_n, cmd.load, !m_axis_tvalid || m_axis_tready, "result register overwritten before transfer")
	`ASSERT_NEXT(a_valid_rises_on_load, clk, arst_n, !m_axis_tvalid && !cmd.load, !m_axis_tvalid, "result valid without a finished check")
	`ASSERT_IMPL(a_no_event_channel_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser, event_channel == '0, "channel nonzero when no event found")
	`ASSERT_IMPL(a_update_only_on_hit, clk, arst_n, cmd.update, cmd.load && sts.hit, "last-reported sample updated without a reported event")

endmodule
